FILE: src/rrls_pkg.sv
// Package with the shared types and constants of the round-robin lock scheduler.
`default_nettype none
package rrls_pkg;

    localparam int VAR_COUNT  = 26;
    localparam int ELAPSED_W  = 9;

    typedef enum logic [2:0] {
        OP_ASSIGN = 3'd0,
        OP_PRINT  = 3'd1,
        OP_LOCK   = 3'd2,
        OP_UNLOCK = 3'd3,
        OP_END    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        RES_PRINT = 2'd0,
        RES_FETCH = 2'd1,
        RES_DONE  = 2'd2
    } res_kind_t;

    typedef enum logic [2:0] {
        CFG_PROGRAM_COUNT = 3'd0,
        CFG_COST_ASSIGN   = 3'd1,
        CFG_COST_PRINT    = 3'd2,
        CFG_COST_LOCK     = 3'd3,
        CFG_COST_UNLOCK   = 3'd4,
        CFG_QUANTUM       = 3'd5
    } cfg_index_t;

    localparam logic KIND_START     = 1'b0;
    localparam logic KIND_STATEMENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN,
        ST_TURN,
        ST_TURN_RD,
        ST_TURN_PC
    } state_t;

endpackage
`default_nettype wire

FILE: src/rrls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rrls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: src/round_robin_lock_scheduler.sv
// Top level of the round-robin scheduler with one mutex.
//
// Input stream s_: tuser carries kind (start a run or statement), tdata the
// decoded statement. Result stream m_: tuser carries the result kind, tlast
// marks the final result of a transaction, tdata the program, pc and value.
// Configuration channel cfg_: register index and data, always ready.
//
// One transaction is handled at a time. From acceptance to the final
// result: a statement that continues the turn is executed and then its pc
// is written back with the fetch request; one that ends or blocks the
// program goes on to the next turn, and one whose quantum runs out does so
// after the pc write-back. In the next turn the next program is read from
// the queue memory and then its pc from the state memory; a start goes
// straight to the next turn, which gives the done result at once when no
// program takes part. s_tready returns with the final result. Variables and
// program counters sit in one memory, the ready deque and blocked FIFO in
// another; both have registered read data.
//
// Reset empties the queues, frees the mutex and stops the run; a start
// clears variables and counters through valid bits with no sweep. When the
// receiver stalls, the held result blocks further progress and s_tready
// stays low until the transaction is complete.
`default_nettype none
module round_robin_lock_scheduler
    import rrls_pkg::*;
#(
    parameter int MAX_PROGRAMS   = 16,
    parameter int MAX_STATEMENTS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // op[2:0], var_index[7:3], assign_value[23:8]
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // program_res[3:0], fetch_pc[11:4],
                                        // print_value[27:12], zero[31:28]
    output logic      [1:0]  m_tuser,   // result_kind
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int PW     = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;
    localparam int CW     = $clog2(MAX_PROGRAMS + 1);
    localparam int PCW    = $clog2(MAX_STATEMENTS);
    localparam int ADEPTH = VAR_COUNT + MAX_PROGRAMS;
    localparam int AAW    = $clog2(ADEPTH);
    localparam int BDEPTH = 2 * MAX_PROGRAMS;
    localparam int BAW    = $clog2(BDEPTH);

    state_t state_reg, state_next;

    logic [4:0] program_count_reg;
    logic [7:0] cost_assign_reg, cost_print_reg, cost_lock_reg, cost_unlock_reg, quantum_reg;

    logic [PW-1:0]        cur_reg, cur_next;
    logic [PCW-1:0]       cur_pc_reg, cur_pc_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 running_reg, running_next;
    logic                 mutex_reg, mutex_next;
    logic [PW-1:0]        rh_reg, rh_next, bh_reg, bh_next, rd_idx_reg, rd_idx_next;
    logic [CW-1:0]        rc_reg, rc_next, bc_reg, bc_next;
    logic [2:0]           op_reg, op_next;
    logic [AAW-1:0]       a_rd_addr_reg, a_rd_addr_next;
    logic                 var_ok_reg, var_ok_next;
    logic [15:0]          val_reg, val_next;
    logic [ADEPTH-1:0]    a_valid_reg, a_valid_next;
    logic [MAX_PROGRAMS-1:0] r_valid_reg, r_valid_next;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;

    logic              a_we, b_we;
    logic [AAW-1:0]    a_waddr, a_raddr;
    logic [15:0]       a_wdata, a_rdata;
    logic [BAW-1:0]    b_waddr, b_raddr;
    logic [PW-1:0]     b_wdata, b_rdata;

    logic              emit;
    res_kind_t         e_kind;
    logic [PW-1:0]     e_prog;
    logic [PCW-1:0]    e_pc;
    logic [15:0]       e_val;
    logic              e_last;

    logic              out_free;
    logic [7:0]        q_eff;
    logic [4:0]        in_vi;
    logic [PCW-1:0]    pc_inc;
    logic [15:0]       var_val;
    logic [PW-1:0]     rd_prog;
    logic [CW:0]       sum_idx;
    logic [PW-1:0]     tail_idx, btail_idx, rh_dec;

    rrls_ram #(.WIDTH(16), .DEPTH(ADEPTH)) u_state_ram (
        .aclk (aclk), .we (a_we), .waddr (a_waddr), .wdata (a_wdata),
        .raddr (a_raddr), .rdata (a_rdata)
    );

    rrls_ram #(.WIDTH(PW), .DEPTH(BDEPTH)) u_queue_ram (
        .aclk (aclk), .we (b_we), .waddr (b_waddr), .wdata (b_wdata),
        .raddr (b_raddr), .rdata (b_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign q_eff     = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
    assign in_vi     = s_tdata[7:3];
    assign pc_inc    = (32'(cur_pc_reg) < MAX_STATEMENTS - 1) ? cur_pc_reg + 1'b1 : cur_pc_reg;
    assign var_val   = (var_ok_reg && a_valid_reg[a_rd_addr_reg]) ? a_rdata : 16'd0;
    assign rd_prog   = r_valid_reg[rd_idx_reg] ? b_rdata : rd_idx_reg;
    assign rh_dec    = (rh_reg == '0) ? PW'(MAX_PROGRAMS - 1) : rh_reg - 1'b1;

    always_comb begin
        sum_idx = (CW+1)'(rh_reg) + (CW+1)'(rc_reg);
        if (32'(sum_idx) >= MAX_PROGRAMS) begin
            sum_idx = sum_idx - (CW+1)'(MAX_PROGRAMS);
        end
        tail_idx = PW'(sum_idx);
    end

    always_comb begin
        logic [CW:0] s;
        s = (CW+1)'(bh_reg) + (CW+1)'(bc_reg);
        if (32'(s) >= MAX_PROGRAMS) begin
            s = s - (CW+1)'(MAX_PROGRAMS);
        end
        btail_idx = PW'(s);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == KIND_START) begin
                        state_next = ST_TURN;
                    end else if (running_reg) begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    priority if (op_reg == OP_LOCK && mutex_reg) begin
                        state_next = ST_TURN;
                    end else if (op_reg == OP_ASSIGN || op_reg == OP_PRINT
                                 || op_reg == OP_LOCK || op_reg == OP_UNLOCK) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_TURN;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = (elapsed_reg < ELAPSED_W'(q_eff)) ? ST_IDLE : ST_TURN;
                end
            end
            ST_TURN: begin
                if (out_free) begin
                    state_next = (rc_reg == '0) ? ST_IDLE : ST_TURN_RD;
                end
            end
            ST_TURN_RD: state_next = ST_TURN_PC;
            ST_TURN_PC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cur_next       = cur_reg;
        cur_pc_next    = cur_pc_reg;
        elapsed_next   = elapsed_reg;
        running_next   = running_reg;
        mutex_next     = mutex_reg;
        rh_next        = rh_reg;
        rc_next        = rc_reg;
        bh_next        = bh_reg;
        bc_next        = bc_reg;
        rd_idx_next    = rd_idx_reg;
        op_next        = op_reg;
        a_rd_addr_next = a_rd_addr_reg;
        var_ok_next    = var_ok_reg;
        val_next       = val_reg;
        a_valid_next   = a_valid_reg;
        r_valid_next   = r_valid_reg;
        a_we    = 1'b0;
        a_waddr = '0;
        a_wdata = '0;
        a_raddr = a_rd_addr_reg;
        b_we    = 1'b0;
        b_waddr = '0;
        b_wdata = '0;
        b_raddr = BAW'(MAX_PROGRAMS) + BAW'(bh_reg);
        emit    = 1'b0;
        e_kind  = RES_FETCH;
        e_prog  = cur_reg;
        e_pc    = '0;
        e_val   = '0;
        e_last  = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                a_raddr = (in_vi < 5'(VAR_COUNT)) ? AAW'(in_vi) : '0;
                if (s_tvalid) begin
                    op_next        = s_tdata[2:0];
                    val_next       = s_tdata[23:8];
                    var_ok_next    = in_vi < 5'(VAR_COUNT);
                    a_rd_addr_next = a_raddr;
                    if (s_tuser == KIND_START) begin
                        a_valid_next = '0;
                        r_valid_next = '0;
                        rh_next      = '0;
                        bh_next      = '0;
                        bc_next      = '0;
                        mutex_next   = 1'b0;
                        rc_next      = (32'(program_count_reg) > MAX_PROGRAMS)
                                       ? CW'(MAX_PROGRAMS) : CW'(program_count_reg);
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    unique case (op_reg)
                        OP_ASSIGN: begin
                            if (var_ok_reg) begin
                                a_we    = 1'b1;
                                a_waddr = a_rd_addr_reg;
                                a_wdata = val_reg;
                                a_valid_next[a_rd_addr_reg] = 1'b1;
                            end
                            elapsed_next = elapsed_reg + ELAPSED_W'(cost_assign_reg);
                        end
                        OP_PRINT: begin
                            emit   = 1'b1;
                            e_kind = RES_PRINT;
                            e_val  = var_val;
                            e_last = 1'b0;
                            elapsed_next = elapsed_reg + ELAPSED_W'(cost_print_reg);
                        end
                        OP_LOCK: begin
                            if (mutex_reg) begin
                                if (32'(bc_reg) < MAX_PROGRAMS) begin
                                    b_we    = 1'b1;
                                    b_waddr = BAW'(MAX_PROGRAMS) + BAW'(btail_idx);
                                    b_wdata = cur_reg;
                                    bc_next = bc_reg + 1'b1;
                                end
                            end else begin
                                mutex_next   = 1'b1;
                                elapsed_next = elapsed_reg + ELAPSED_W'(cost_lock_reg);
                            end
                        end
                        OP_UNLOCK: begin
                            mutex_next   = 1'b0;
                            elapsed_next = elapsed_reg + ELAPSED_W'(cost_unlock_reg);
                            if (bc_reg != '0) begin
                                bh_next = (32'(bh_reg) == MAX_PROGRAMS - 1) ? '0 : bh_reg + 1'b1;
                                bc_next = bc_reg - 1'b1;
                                if (32'(rc_reg) < MAX_PROGRAMS) begin
                                    rh_next = rh_dec;
                                    rc_next = rc_reg + 1'b1;
                                    b_we    = 1'b1;
                                    b_waddr = BAW'(rh_dec);
                                    b_wdata = b_rdata;
                                    r_valid_next[rh_dec] = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    a_we        = 1'b1;
                    a_waddr     = AAW'(VAR_COUNT) + AAW'(cur_reg);
                    a_wdata     = 16'(pc_inc);
                    a_valid_next[AAW'(VAR_COUNT) + AAW'(cur_reg)] = 1'b1;
                    cur_pc_next = pc_inc;
                    if (elapsed_reg < ELAPSED_W'(q_eff)) begin
                        emit = 1'b1;
                        e_pc = pc_inc;
                    end else if (32'(rc_reg) < MAX_PROGRAMS) begin
                        b_we    = 1'b1;
                        b_waddr = BAW'(tail_idx);
                        b_wdata = cur_reg;
                        rc_next = rc_reg + 1'b1;
                        r_valid_next[tail_idx] = 1'b1;
                    end
                end
            end
            ST_TURN: begin
                b_raddr = BAW'(rh_reg);
                if (out_free) begin
                    if (rc_reg == '0) begin
                        running_next = 1'b0;
                        emit   = 1'b1;
                        e_kind = RES_DONE;
                        e_prog = '0;
                    end else begin
                        rd_idx_next  = rh_reg;
                        rh_next      = (32'(rh_reg) == MAX_PROGRAMS - 1) ? '0 : rh_reg + 1'b1;
                        rc_next      = rc_reg - 1'b1;
                        elapsed_next = '0;
                    end
                end
            end
            ST_TURN_RD: begin
                cur_next       = rd_prog;
                a_raddr        = AAW'(VAR_COUNT) + AAW'(rd_prog);
                a_rd_addr_next = a_raddr;
            end
            ST_TURN_PC: begin
                if (out_free) begin
                    cur_pc_next  = a_valid_reg[a_rd_addr_reg] ? a_rdata[PCW-1:0] : '0;
                    running_next = 1'b1;
                    emit         = 1'b1;
                    e_pc         = cur_pc_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            program_count_reg <= 5'd1;
            cost_assign_reg   <= 8'd1;
            cost_print_reg    <= 8'd1;
            cost_lock_reg     <= 8'd1;
            cost_unlock_reg   <= 8'd1;
            quantum_reg       <= 8'd1;
            cur_reg           <= '0;
            cur_pc_reg        <= '0;
            elapsed_reg       <= '0;
            running_reg       <= 1'b0;
            mutex_reg         <= 1'b0;
            rh_reg            <= '0;
            rc_reg            <= '0;
            bh_reg            <= '0;
            bc_reg            <= '0;
            a_valid_reg       <= '0;
            r_valid_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            cur_pc_reg  <= cur_pc_next;
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
            mutex_reg   <= mutex_next;
            rh_reg      <= rh_next;
            rc_reg      <= rc_next;
            bh_reg      <= bh_next;
            bc_reg      <= bc_next;
            a_valid_reg <= a_valid_next;
            r_valid_reg <= r_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PROGRAM_COUNT: program_count_reg <= cfg_data[4:0];
                    CFG_COST_ASSIGN:   cost_assign_reg   <= cfg_data;
                    CFG_COST_PRINT:    cost_print_reg    <= cfg_data;
                    CFG_COST_LOCK:     cost_lock_reg     <= cfg_data;
                    CFG_COST_UNLOCK:   cost_unlock_reg   <= cfg_data;
                    CFG_QUANTUM:       quantum_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        op_reg        <= op_next;
        a_rd_addr_reg <= a_rd_addr_next;
        var_ok_reg    <= var_ok_next;
        val_reg       <= val_next;
        if (emit) begin
            m_tdata_reg <= {4'd0, e_val, 8'(e_pc), 4'(e_prog)};
            m_tuser_reg <= e_kind;
            m_tlast_reg <= e_last;
        end
    end

endmodule
`default_nettype wire
